// File: design/flha_pkg.sv
// ----------------------------------------------------------------------------
// Free-list heap allocator package
// Command, status and field width constants shared by the allocator files.
// ----------------------------------------------------------------------------
package flha_pkg;

  localparam int unsigned BYTES_W   = 16;
  localparam int unsigned INDEX_W   = 10;
  localparam int unsigned STATUS_W  = 2;
  localparam int unsigned NEED_W    = 17;
  localparam int unsigned RECIP_SH  = 24;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  localparam logic [STATUS_W-1:0] ST_DONE    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_IGNORED = 2'd1;
  localparam logic [STATUS_W-1:0] ST_OOM     = 2'd2;

endpackage

// File: design/free_list_heap_allocator_core.sv
// ----------------------------------------------------------------------------
// Free-list heap allocator core
// Next-fit allocator over an address-ordered circular free list kept in two
// synchronous memories (link and size), walked one block per cycle.
// ----------------------------------------------------------------------------
// An allocate steps S_A_MUL, S_A_NEED, S_A_ROV, then S_A_WALK per free block
// visited and S_A_SPLIT when the block is split; a free steps S_F_SRCH per link
// searched, then S_F_RBP, S_F_RNX, S_F_WP. One command is in flight at a time,
// set by the memory walk. After reset the block clears its memories with busy
// high. Each result is shown for one cycle on out_valid; no stall is possible.
module free_list_heap_allocator_core #(
  parameter int unsigned HEAP_UNITS = 1024,
  parameter int unsigned UNIT_BYTES = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic                              in_cmd,
  input  logic [flha_pkg::BYTES_W-1:0]      in_request_bytes,
  input  logic [flha_pkg::INDEX_W-1:0]      in_free_index,
  output logic                              out_valid,
  output logic [flha_pkg::INDEX_W-1:0]      out_payload_index,
  output logic [flha_pkg::STATUS_W-1:0]     out_status
);
  import flha_pkg::*;

  localparam int unsigned IW = $clog2(HEAP_UNITS);
  localparam int unsigned UW = IW + 1;
  localparam int unsigned SW = UW + 1;
  localparam int unsigned CW = (UW > NEED_W) ? UW : NEED_W;
  localparam int unsigned PW = (SW > INDEX_W) ? SW : INDEX_W;
  localparam int unsigned RW = NEED_W + 8;
  localparam int unsigned RECIP = ((1 << RECIP_SH) + UNIT_BYTES - 1) / UNIT_BYTES;
  localparam int unsigned MW = NEED_W + RW;

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_A_MUL, S_A_NEED, S_A_ROV, S_A_WALK, S_A_SPLIT,
    S_F_SRCH, S_F_RBP, S_F_RNX, S_F_WP
  } state_t;

  state_t         state_r;
  logic [IW-1:0]  nl_mem [HEAP_UNITS];
  logic [UW-1:0]  bu_mem [HEAP_UNITS];

  logic [IW-1:0]  rd_next_raw_r;
  logic [UW-1:0]  rd_units_raw_r;
  logic           rd_oob_r;
  logic [IW-1:0]  rd_addr;
  logic [IW-1:0]  wa;
  logic           we_nl;
  logic           we_bu;
  logic [IW-1:0]  wd_nl;
  logic [UW-1:0]  wd_bu;

  logic [IW-1:0]  rover_r;
  logic [IW-1:0]  clr_cnt_r;
  logic [IW:0]    n_r;
  logic [IW-1:0]  p_r;
  logic [IW-1:0]  prev_r;
  logic [IW-1:0]  bp_r;
  logic [IW-1:0]  nx_r;
  logic [UW-1:0]  up_r;
  logic [UW-1:0]  ubp_r;
  logic [UW-1:0]  pu_r;
  logic [IW-1:0]  pn_r;
  logic           m2_r;
  logic [NEED_W-1:0] bytes_r;
  logic [MW-1:0]  prod_r;
  logic [CW-1:0]  need_r;
  logic [SW-1:0]  split_r;
  logic           out_valid_r;
  logic [INDEX_W-1:0]  out_payload_r;
  logic [STATUS_W-1:0] out_status_r;

  logic [IW-1:0]  rd_next;
  logic [UW-1:0]  rd_units;
  logic           fit;
  logic           exact;
  logic [UW-1:0]  sz_rem;
  logic [SW-1:0]  split_addr;
  logic           found;
  logic           m1;
  logic [UW-1:0]  ubp1;
  logic [IW-1:0]  nbp1;
  logic           m2;
  logic [PW-1:0]  pay_exact;
  logic [PW-1:0]  pay_split;
  logic [NEED_W-1:0] need_q;
  logic [31:0]    idx32;
  logic           accept;

  assign accept     = start && (state_r == S_IDLE);
  assign rd_next    = rd_oob_r ? '0 : rd_next_raw_r;
  assign rd_units   = rd_oob_r ? '0 : rd_units_raw_r;
  assign fit        = CW'(rd_units) >= need_r;
  assign exact      = CW'(rd_units) == need_r;
  assign sz_rem     = UW'(CW'(rd_units) - need_r);
  assign split_addr = SW'(p_r) + SW'(sz_rem);
  assign found      = ((bp_r > p_r) && (bp_r < rd_next)) ||
                      ((p_r >= rd_next) && ((bp_r > p_r) || (bp_r < rd_next)));
  assign m1         = (SW'(bp_r) + SW'(ubp_r)) == SW'(nx_r);
  assign ubp1       = m1 ? UW'(ubp_r + rd_units) : ubp_r;
  assign nbp1       = m1 ? rd_next : nx_r;
  assign m2         = (SW'(p_r) + SW'(up_r)) == SW'(bp_r);
  assign pay_exact  = PW'(p_r) + PW'(1);
  assign pay_split  = PW'(split_r) + PW'(1);
  assign need_q     = NEED_W'(prod_r >> RECIP_SH) + NEED_W'(1);
  assign idx32      = 32'(in_free_index);

  always_comb begin
    rd_addr = rover_r;
    we_nl   = 1'b0;
    we_bu   = 1'b0;
    wa      = p_r;
    wd_nl   = '0;
    wd_bu   = '0;
    case (state_r)
      S_CLR: begin
        we_nl = 1'b1;
        we_bu = 1'b1;
        wa    = clr_cnt_r;
        wd_nl = (clr_cnt_r == IW'(0)) ? IW'(1) : '0;
        wd_bu = (clr_cnt_r == IW'(1)) ? UW'(HEAP_UNITS - 1) : '0;
      end
      S_A_ROV: rd_addr = rd_next;
      S_A_WALK: begin
        rd_addr = rd_next;
        if (fit && exact) begin
          we_nl = 1'b1;
          wa    = prev_r;
          wd_nl = rd_next;
        end else if (fit) begin
          we_bu = 1'b1;
          wa    = p_r;
          wd_bu = sz_rem;
        end
      end
      S_A_SPLIT: begin
        we_bu = split_r < SW'(HEAP_UNITS);
        wa    = IW'(split_r);
        wd_bu = UW'(need_r);
      end
      S_F_SRCH: rd_addr = found ? bp_r : rd_next;
      S_F_RBP:  rd_addr = nx_r;
      S_F_RNX: begin
        we_nl = 1'b1;
        we_bu = 1'b1;
        wa    = bp_r;
        wd_nl = nbp1;
        wd_bu = ubp1;
      end
      S_F_WP: begin
        we_nl = 1'b1;
        we_bu = m2_r;
        wa    = p_r;
        wd_nl = pn_r;
        wd_bu = pu_r;
      end
      default: rd_addr = rover_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we_nl && ({1'b0, wa} < (IW + 1)'(HEAP_UNITS))) begin
      nl_mem[wa] <= wd_nl;
    end
    if ({1'b0, rd_addr} < (IW + 1)'(HEAP_UNITS)) begin
      rd_next_raw_r <= nl_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (we_bu && ({1'b0, wa} < (IW + 1)'(HEAP_UNITS))) begin
      bu_mem[wa] <= wd_bu;
    end
    if ({1'b0, rd_addr} < (IW + 1)'(HEAP_UNITS)) begin
      rd_units_raw_r <= bu_mem[rd_addr];
    end
    rd_oob_r <= {1'b0, rd_addr} >= (IW + 1)'(HEAP_UNITS);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_CLR;
      clr_cnt_r     <= '0;
      rover_r       <= '0;
      out_valid_r   <= 1'b0;
      out_payload_r <= '0;
      out_status_r  <= ST_DONE;
    end else begin
      out_valid_r <= 1'b0;
      case (state_r)
        S_CLR: begin
          clr_cnt_r <= clr_cnt_r + IW'(1);
          if (clr_cnt_r == IW'(HEAP_UNITS - 1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            if (in_cmd == CMD_ALLOC) begin
              if (in_request_bytes == '0) begin
                out_valid_r   <= 1'b1;
                out_payload_r <= '0;
                out_status_r  <= ST_IGNORED;
              end else begin
                bytes_r <= NEED_W'(in_request_bytes) + NEED_W'(UNIT_BYTES - 1);
                state_r <= S_A_MUL;
              end
            end else begin
              if (idx32 == 32'd0 || idx32 >= 32'(HEAP_UNITS)) begin
                out_valid_r   <= 1'b1;
                out_payload_r <= '0;
                out_status_r  <= ST_IGNORED;
              end else begin
                bp_r    <= IW'(idx32 - 32'd1);
                p_r     <= rover_r;
                n_r     <= '0;
                state_r <= S_F_SRCH;
              end
            end
          end
        end
        S_A_MUL: begin
          prod_r  <= MW'(bytes_r) * MW'(RECIP);
          state_r <= S_A_NEED;
        end
        S_A_NEED: begin
          need_r  <= (need_q < NEED_W'(2)) ? CW'(2) : CW'(need_q);
          state_r <= S_A_ROV;
        end
        S_A_ROV: begin
          prev_r  <= rover_r;
          p_r     <= rd_next;
          n_r     <= '0;
          state_r <= S_A_WALK;
        end
        S_A_WALK: begin
          if (fit && exact) begin
            rover_r       <= prev_r;
            out_valid_r   <= 1'b1;
            out_payload_r <= pay_exact[INDEX_W-1:0];
            out_status_r  <= ST_DONE;
            state_r       <= S_IDLE;
          end else if (fit) begin
            rover_r <= prev_r;
            split_r <= split_addr;
            state_r <= S_A_SPLIT;
          end else if (p_r == rover_r || n_r == (IW + 1)'(HEAP_UNITS)) begin
            out_valid_r   <= 1'b1;
            out_payload_r <= '0;
            out_status_r  <= ST_OOM;
            state_r       <= S_IDLE;
          end else begin
            prev_r <= p_r;
            p_r    <= rd_next;
            n_r    <= n_r + (IW + 1)'(1);
          end
        end
        S_A_SPLIT: begin
          out_valid_r   <= 1'b1;
          out_payload_r <= pay_split[INDEX_W-1:0];
          out_status_r  <= ST_DONE;
          state_r       <= S_IDLE;
        end
        S_F_SRCH: begin
          if (found) begin
            nx_r    <= rd_next;
            up_r    <= rd_units;
            state_r <= S_F_RBP;
          end else if (n_r == (IW + 1)'(HEAP_UNITS)) begin
            out_valid_r   <= 1'b1;
            out_payload_r <= '0;
            out_status_r  <= ST_IGNORED;
            state_r       <= S_IDLE;
          end else begin
            p_r <= rd_next;
            n_r <= n_r + (IW + 1)'(1);
          end
        end
        S_F_RBP: begin
          ubp_r   <= rd_units;
          state_r <= S_F_RNX;
        end
        S_F_RNX: begin
          m2_r    <= m2;
          pu_r    <= UW'(up_r + ubp1);
          pn_r    <= m2 ? nbp1 : bp_r;
          state_r <= S_F_WP;
        end
        S_F_WP: begin
          rover_r       <= p_r;
          out_valid_r   <= 1'b1;
          out_payload_r <= '0;
          out_status_r  <= ST_DONE;
          state_r       <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign busy              = state_r != S_IDLE;
  assign out_valid         = out_valid_r;
  assign out_payload_index = out_payload_r;
  assign out_status        = out_status_r;

  a_status_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == ST_DONE || out_status == ST_IGNORED ||
                   out_status == ST_OOM))
    else $error("Result transfer carries an unused status code.");

  a_payload_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_DONE) |-> (out_payload_index == '0))
    else $error("Failed command returned a nonzero payload index.");

  a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_A_WALK || state_r == S_F_SRCH) |-> (n_r <= (IW + 1)'(HEAP_UNITS)))
    else $error("List walk ran past its link limit.");

  a_single_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid || $past(accept))
    else $error("Result strobe held without a new command.");

endmodule

// File: test/free_list_heap_allocator_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Free-list heap allocator core testbench
// Drives allocate and free commands through the start/busy handshake, keeps
// its own next-fit free-list model to predict every result, and checks each
// strobed result in order. Directed edge cases come first, then a long
// random mix of well-formed allocate/free traffic with some noise.
// ----------------------------------------------------------------------------
module free_list_heap_allocator_core_test;
  import flha_pkg::*;

  localparam int unsigned POOL_UNITS = 1024;
  localparam int unsigned UNIT_SIZE  = 16;
  localparam int unsigned CYCLE_LIMIT = 4000000;

  typedef struct packed {
    logic [INDEX_W-1:0]  payload_index;
    logic [STATUS_W-1:0] status;
  } alloc_result_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  logic                in_cmd = CMD_ALLOC;
  logic [BYTES_W-1:0]  in_request_bytes = '0;
  logic [INDEX_W-1:0]  in_free_index = '0;
  logic                out_valid;
  logic [INDEX_W-1:0]  out_payload_index;
  logic [STATUS_W-1:0] out_status;

  int unsigned   link_mem [POOL_UNITS];
  int unsigned   size_mem [POOL_UNITS];
  int unsigned   rover_idx;
  int unsigned   live_blocks [$];
  alloc_result_t pending_results [$];
  int unsigned   mismatches = 0;
  int unsigned   cycle_count = 0;
  bit            idle_gaps = 1'b1;

  free_list_heap_allocator_core dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_cmd(in_cmd), .in_request_bytes(in_request_bytes),
    .in_free_index(in_free_index), .out_valid(out_valid),
    .out_payload_index(out_payload_index), .out_status(out_status)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[free_list_heap_allocator_core] ERROR");
      $finish;
    end
  end

  function automatic int unsigned rd_link(int unsigned i);
    return (i < POOL_UNITS) ? link_mem[i] : 0;
  endfunction

  function automatic int unsigned rd_size(int unsigned i);
    return (i < POOL_UNITS) ? size_mem[i] : 0;
  endfunction

  task automatic wr_link(int unsigned i, int unsigned v);
    if (i < POOL_UNITS) link_mem[i] = v;
  endtask

  task automatic wr_size(int unsigned i, int unsigned v);
    if (i < POOL_UNITS) size_mem[i] = v;
  endtask

  task automatic heap_reset();
    foreach (link_mem[i]) begin
      link_mem[i] = 0;
      size_mem[i] = 0;
    end
    link_mem[0] = 1;
    size_mem[1] = POOL_UNITS - 1;
    rover_idx = 0;
  endtask

  task automatic heap_alloc(input int unsigned nbytes, output alloc_result_t r);
    int unsigned need, prev, p, sz;
    r = '0;
    if (nbytes == 0) begin
      r.status = ST_IGNORED;
      return;
    end
    need = (nbytes + UNIT_SIZE - 1) / UNIT_SIZE + 1;
    if (need < 2) need = 2;
    prev = rover_idx;
    p = rd_link(prev);
    for (int unsigned n = 0; n <= POOL_UNITS; n++) begin
      sz = rd_size(p);
      if (sz >= need) begin
        if (sz == need) begin
          wr_link(prev, rd_link(p));
        end else begin
          sz -= need;
          wr_size(p, sz);
          p += sz;
          wr_size(p, need);
        end
        rover_idx = prev;
        r.payload_index = INDEX_W'(p + 1);
        r.status = ST_DONE;
        live_blocks.push_back(r.payload_index);
        return;
      end
      if (p == rover_idx) break;
      prev = p;
      p = rd_link(p);
    end
    r.status = ST_OOM;
  endtask

  task automatic heap_free(input int unsigned idx, output alloc_result_t r);
    int unsigned bp, p, nx;
    bit found;
    found = 1'b0;
    r = '0;
    r.status = ST_IGNORED;
    if (idx == 0 || idx >= POOL_UNITS) return;
    bp = idx - 1;
    p = rover_idx;
    for (int unsigned n = 0; n <= POOL_UNITS; n++) begin
      nx = rd_link(p);
      if (bp > p && bp < nx) begin
        found = 1'b1;
        break;
      end
      if (p >= nx && (bp > p || bp < nx)) begin
        found = 1'b1;
        break;
      end
      p = nx;
    end
    if (!found) return;
    nx = rd_link(p);
    if (bp + rd_size(bp) == nx) begin
      wr_size(bp, rd_size(bp) + rd_size(nx));
      wr_link(bp, rd_link(nx));
    end else begin
      wr_link(bp, nx);
    end
    if (p + rd_size(p) == bp) begin
      wr_size(p, rd_size(p) + rd_size(bp));
      wr_link(p, rd_link(bp));
    end else begin
      wr_link(p, bp);
    end
    rover_idx = p;
    r.status = ST_DONE;
    foreach (live_blocks[i]) begin
      if (live_blocks[i] == idx) begin
        live_blocks.delete(i);
        break;
      end
    end
  endtask

  // Payload index of a random block that is currently on the free list.
  function automatic int unsigned pick_free_header();
    int unsigned heads [$];
    int unsigned p;
    p = link_mem[0];
    for (int unsigned n = 0; n <= POOL_UNITS && p != 0; n++) begin
      if (p < POOL_UNITS - 1) heads.push_back(p + 1);
      p = rd_link(p);
    end
    if (heads.size() == 0) return 0;
    return heads[$urandom_range(0, heads.size() - 1)];
  endfunction

  // Called at a falling clock edge; returns at a falling clock edge.
  task automatic send_command(logic cmd, int unsigned nbytes, int unsigned idx);
    alloc_result_t r;
    start <= 1'b1;
    in_cmd <= cmd;
    in_request_bytes <= BYTES_W'(nbytes);
    in_free_index <= INDEX_W'(idx);
    do @(posedge clk); while (busy);
    if (cmd == CMD_ALLOC) heap_alloc(nbytes, r);
    else heap_free(idx, r);
    pending_results.push_back(r);
    @(negedge clk);
    if (idle_gaps && $urandom_range(0, 2) == 0) begin
      start <= 1'b0;
      in_cmd <= 1'($urandom_range(0, 1));
      in_request_bytes <= BYTES_W'($urandom);
      in_free_index <= INDEX_W'($urandom);
      repeat ($urandom_range(1, 7)) @(negedge clk);
    end
  endtask

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    $display("mismatch on %s: got %0d, expected %0d at cycle %0d",
             what, got, want, cycle_count);
    mismatches++;
  endtask

  always @(posedge clk) begin
    alloc_result_t want;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", out_status, 0);
      end else begin
        want = pending_results.pop_front();
        if (out_payload_index !== want.payload_index)
          report_mismatch("payload_index", out_payload_index, want.payload_index);
        if (out_status !== want.status)
          report_mismatch("status", out_status, want.status);
      end
    end
  end

  task automatic test_alloc_edges();
    send_command(CMD_ALLOC, 1, 0);
    send_command(CMD_ALLOC, 0, 0);
    send_command(CMD_ALLOC, 16, 0);
    send_command(CMD_ALLOC, 17, 0);
    send_command(CMD_ALLOC, 65535, 0);
    send_command(CMD_ALLOC, 32768, 0);
  endtask

  task automatic test_free_edges();
    send_command(CMD_FREE, 0, 0);
    send_command(CMD_FREE, 0, 1);
    send_command(CMD_FREE, 0, 1023);
    send_command(CMD_FREE, 0, 1023);
    send_command(CMD_FREE, 0, pick_free_header());
    while (live_blocks.size() > 0) send_command(CMD_FREE, 0, live_blocks[$]);
  endtask

  task automatic test_fill_and_drain();
    int unsigned k;
    for (int unsigned n = 0; n < 70; n++) send_command(CMD_ALLOC, 256, 0);
    while (live_blocks.size() > 0) begin
      k = $urandom_range(0, live_blocks.size() - 1);
      send_command(CMD_FREE, 0, live_blocks[k]);
    end
    send_command(CMD_ALLOC, 16352, 0);
    send_command(CMD_ALLOC, 1, 0);
    send_command(CMD_FREE, 0, live_blocks[0]);
  endtask

  task automatic test_random_traffic(int unsigned count);
    int unsigned sel, nbytes;
    for (int unsigned n = 0; n < count; n++) begin
      sel = $urandom_range(0, 99);
      if (sel < 50 || live_blocks.size() == 0) begin
        case ($urandom_range(0, 9))
          0: nbytes = $urandom;
          1: nbytes = $urandom_range(0, 16);
          default: nbytes = $urandom_range(1, 600);
        endcase
        send_command(CMD_ALLOC, nbytes & 16'hffff, 0);
      end else if (sel < 90) begin
        send_command(CMD_FREE, $urandom, live_blocks[$urandom_range(0, live_blocks.size() - 1)]);
      end else begin
        case ($urandom_range(0, 2))
          0: send_command(CMD_FREE, 0, 0);
          1: send_command(CMD_FREE, 0, 1);
          default: send_command(CMD_FREE, 0, pick_free_header());
        endcase
      end
    end
  endtask

  initial begin
    heap_reset();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_alloc_edges();
    test_free_edges();
    test_fill_and_drain();
    test_random_traffic(480);
    idle_gaps = 1'b0;
    test_random_traffic(160);
    start <= 1'b0;
    wait (pending_results.size() == 0);
    repeat (50) @(posedge clk);
    if (mismatches == 0) begin
      $display("[free_list_heap_allocator_core] OK");
    end else begin
      $display("[free_list_heap_allocator_core] ERROR");
    end
    $finish;
  end

endmodule

// File: free_list_heap_allocator_core.f
design/flha_pkg.sv
design/free_list_heap_allocator_core.sv
test/free_list_heap_allocator_core_test.sv
